// ----- sv/hctk_pkg.sv -----
package hctk_pkg;

    localparam int MAX_HITS  = 16;
    localparam int IDX_W     = $clog2(MAX_HITS);
    localparam int OCC_W     = $clog2(MAX_HITS + 1);
    localparam int SNAP_REGS = 8;
    localparam logic [31:0] TALLY_TOP = 32'hFFFF_FFFF;

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_SPARE  = 2'd3;

    typedef struct packed {
        logic [31:0]                 key;
        logic [31:0]                 tally;
        logic [SNAP_REGS-1:0][31:0]  snap;
    } entry_t;

    // Commands broadcast from the sequencer to every cell.
    typedef struct packed {
        logic        bump;     // increment the cell whose key matches
        logic        append;   // write the cell at index wr_idx
        logic [IDX_W-1:0] wr_idx;
        logic        take_clr; // any accepted input word: clear taken flags
        logic        take;     // mark the winner of the current pass
        logic [IDX_W-1:0] take_idx;
    } cell_cmd_t;

    // Running best, handed from cell to cell along the chain.
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [31:0]      tally;
    } best_t;

endpackage

// ----- sv/hit_counter_table_topk_unit.sv -----
// Trap hit table with sorted readout.
// Words arrive on s_axis: operation, trap address, eight trap registers and read
// limit. A record word (acted on only while the configuration register enables
// recording) bumps the saturating count of a matching entry or appends a new one;
// a full table drops new addresses. A clear word empties the table. A read word
// emits min(read_limit, occupancy) words on m_axis, largest count first, ties to
// the lower index, with tlast on the final word. The register is written on cfg.
// Record, clear and unused words are accepted, then handled in S_REC, in which
// every cell compares its key in parallel. For a read the cells hand the running
// best along the chain one cell per cycle, and each selection pass waits until
// it has reached the end of the chain before a word is loaded. The next input
// word is accepted only after the last result word is loaded and the unit is
// back to idle. One item is in flight at a time; s_axis_tready is low meanwhile.
// When the receiver stalls, the result word is held in the output register and
// the next pass waits for it. Reset empties the table and disables recording;
// entry contents are not cleared, only the fill count.
module hit_counter_table_topk_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[1:0], trap_address[33:2], trap_reg0..7[289:34], read_limit[296:290]
    input  logic [303:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit_address[31:0], hit_count[63:32], snap_reg0..7[319:64],
    // distinct_entries[324:320]
    output logic [327:0] m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data
);

    localparam int IW = hctk_pkg::IDX_W;
    localparam int OW = hctk_pkg::OCC_W;

    typedef enum logic [1:0] {S_IDLE, S_REC, S_READ} state_t;

    state_t           state_reg;
    logic             rec_en_reg;
    logic [OW-1:0]    occ_reg;
    logic [1:0]       op_reg;
    hctk_pkg::entry_t in_reg;
    logic [6:0]       limit_reg;
    logic [OW-1:0]    left_reg;
    logic [OW-1:0]    settle_reg;
    logic             out_valid_reg;
    logic             out_last_reg;
    logic [327:0]     out_data_reg;

    hctk_pkg::cell_cmd_t cmd;
    hctk_pkg::best_t  chain [hctk_pkg::MAX_HITS+1];
    hctk_pkg::entry_t ents  [hctk_pkg::MAX_HITS];
    logic [hctk_pkg::MAX_HITS-1:0] hit_vec;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < hctk_pkg::MAX_HITS; g++)
        begin : g_cell
            localparam logic [IW-1:0] GI = IW'(g);
            hctk_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .my_idx   (GI),
                .filled   (OW'(g) < occ_reg),
                .cmd      (cmd),
                .wr_entry (in_reg),
                .best_in  (chain[g]),
                .best_out (chain[g+1]),
                .match    (hit_vec[g]),
                .entry    (ents[g])
            );
        end
    endgenerate

    // A winner is taken only once the running best has reached the end of the chain.
    logic out_free;
    logic do_emit;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign do_emit  = (state_reg == S_READ) && out_free && (left_reg != '0) &&
                      (settle_reg == '0);

    always_comb
    begin
        cmd          = '0;
        cmd.wr_idx   = occ_reg[IW-1:0];
        cmd.take_idx = chain[hctk_pkg::MAX_HITS].idx;
        cmd.bump     = (state_reg == S_REC) && rec_en_reg && (op_reg == hctk_pkg::OP_RECORD);
        cmd.append   = cmd.bump && (hit_vec == '0) && (occ_reg < OW'(hctk_pkg::MAX_HITS));
        cmd.take_clr = s_axis_tvalid && s_axis_tready;
        cmd.take     = do_emit;
    end

    logic [OW-1:0] n_read;
    always_comb
    begin
        n_read = occ_reg;
        if ({1'b0, limit_reg} < 8'(occ_reg))
        begin
            n_read = OW'(limit_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg       <= s_axis_tdata[1:0];
            in_reg.key   <= s_axis_tdata[33:2];
            in_reg.tally <= 32'd1;
            in_reg.snap  <= s_axis_tdata[289:34];
            limit_reg    <= s_axis_tdata[296:290];
        end
        if (do_emit)
        begin
            out_data_reg <= {3'b0, occ_reg,
                             ents[chain[hctk_pkg::MAX_HITS].idx].snap,
                             ents[chain[hctk_pkg::MAX_HITS].idx].tally,
                             ents[chain[hctk_pkg::MAX_HITS].idx].key};
            out_last_reg <= (left_reg == OW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rec_en_reg    <= 1'b0;
            occ_reg       <= '0;
            left_reg      <= '0;
            settle_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                rec_en_reg <= cfg_data;
            end
            if (do_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        state_reg <= S_REC;
                    end
                end
                S_REC:
                begin
                    if (cmd.append)
                    begin
                        occ_reg <= occ_reg + OW'(1);
                    end
                    if (op_reg == hctk_pkg::OP_CLEAR)
                    begin
                        occ_reg <= '0;
                    end
                    if (op_reg == hctk_pkg::OP_READ)
                    begin
                        left_reg   <= n_read;
                        settle_reg <= OW'(hctk_pkg::MAX_HITS);
                        state_reg  <= S_READ;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_READ:
                begin
                    if (do_emit)
                    begin
                        left_reg   <= left_reg - OW'(1);
                        settle_reg <= OW'(hctk_pkg::MAX_HITS);
                    end
                    else if (left_reg == '0)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (settle_reg != '0)
                    begin
                        settle_reg <= settle_reg - OW'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OW'(hctk_pkg::MAX_HITS)) else $error("occupancy beyond table");
    a_tlast_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (do_emit && left_reg == OW'(1)) |=> m_axis_tlast) else $error("last word unmarked");
    a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_READ) |-> !do_emit) else $error("emit outside read");
    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> occ_reg < OW'(hctk_pkg::MAX_HITS)) else $error("append on full");

endmodule

// ----- sv/hctk_cell.sv -----
module hctk_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [hctk_pkg::IDX_W-1:0] my_idx,
    input  logic                     filled,
    input  hctk_pkg::cell_cmd_t      cmd,
    input  hctk_pkg::entry_t         wr_entry,
    input  hctk_pkg::best_t          best_in,
    output hctk_pkg::best_t          best_out,
    output logic                     match,
    output hctk_pkg::entry_t         entry
);

    hctk_pkg::entry_t ent_reg;
    logic             taken_reg;
    logic             cand;
    hctk_pkg::best_t  best_reg;

    assign entry    = ent_reg;
    assign match    = filled && (ent_reg.key == wr_entry.key);
    assign best_out = best_reg;

    // Strict greater keeps the lower index on ties.
    assign cand = filled && !taken_reg && (!best_in.found || ent_reg.tally > best_in.tally);

    // The running best moves on by one cell per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else if (cand)
        begin
            best_reg <= {1'b1, my_idx, ent_reg.tally};
        end
        else
        begin
            best_reg <= best_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append && cmd.wr_idx == my_idx)
        begin
            ent_reg <= wr_entry;
        end
        else if (cmd.bump && match && ent_reg.tally != hctk_pkg::TALLY_TOP)
        begin
            ent_reg.tally <= ent_reg.tally + 32'd1;
        end
        if (cmd.take_clr)
        begin
            taken_reg <= 1'b0;
        end
        else if (cmd.take && cmd.take_idx == my_idx)
        begin
            taken_reg <= 1'b1;
        end
    end

endmodule

// ----- tb/hctk_checker.sv -----
module hctk_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [303:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [327:0] m_axis_tdata,
    input  logic         m_axis_tlast,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic         cfg_data,
    output int           errors,
    output int           pending_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0]     address;
        logic [31:0]     count;
        logic [31:0]     snap [hctk_pkg::SNAP_REGS];
        logic [4:0]      distinct;
        logic            last;
    } hit_word_t;

    logic [31:0] trap_key   [hctk_pkg::MAX_HITS];
    logic [31:0] trap_tally [hctk_pkg::MAX_HITS];
    logic [31:0] trap_snap  [hctk_pkg::MAX_HITS][hctk_pkg::SNAP_REGS];
    int          fill_level;
    logic        recording;
    hit_word_t   expected_hits [$];

    // Bump a matching key or append a new entry with its register snapshot.
    task automatic log_trap(input logic [303:0] w);
        logic [31:0] addr;
        addr = w[33:2];
        for (int i = 0; i < fill_level; i++)
            if (trap_key[i] == addr)
            begin
                if (trap_tally[i] != hctk_pkg::TALLY_TOP)
                    trap_tally[i] = trap_tally[i] + 32'd1;
                return;
            end
        if (fill_level >= hctk_pkg::MAX_HITS)
            return;
        trap_key[fill_level]   = addr;
        trap_tally[fill_level] = 32'd1;
        for (int r = 0; r < hctk_pkg::SNAP_REGS; r++)
            trap_snap[fill_level][r] = w[34 + 32*r +: 32];
        fill_level++;
    endtask

    // Queue the entries a read emits, largest count first, ties to the lower index.
    task automatic rank_hits(input logic [6:0] limit);
        int          n;
        int          best;
        logic [63:0] taken;
        hit_word_t   h;
        n = limit;
        taken = '0;
        if (n > fill_level)
            n = fill_level;
        for (int k = 0; k < n; k++)
        begin
            best = -1;
            for (int i = 0; i < fill_level; i++)
                if (!taken[i] && (best < 0 || trap_tally[i] > trap_tally[best]))
                    best = i;
            taken[best] = 1'b1;
            h.address  = trap_key[best];
            h.count    = trap_tally[best];
            for (int r = 0; r < hctk_pkg::SNAP_REGS; r++)
                h.snap[r] = trap_snap[best][r];
            h.distinct = fill_level[4:0];
            h.last     = (k == n - 1);
            expected_hits.push_back(h);
        end
    endtask

    task automatic check_hit(input logic [327:0] d, input logic last);
        hit_word_t h;
        if (expected_hits.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result word %h last %b", $time, d, last);
            return;
        end
        h = expected_hits.pop_front();
        if (d[31:0] !== h.address)
        begin
            errors++;
            $display("%0t: hit_address expected %h got %h", $time, h.address, d[31:0]);
        end
        if (d[63:32] !== h.count)
        begin
            errors++;
            $display("%0t: hit_count expected %0d got %0d", $time, h.count, d[63:32]);
        end
        for (int r = 0; r < hctk_pkg::SNAP_REGS; r++)
            if (d[64 + 32*r +: 32] !== h.snap[r])
            begin
                errors++;
                $display("%0t: snap_reg%0d expected %h got %h", $time, r, h.snap[r],
                         d[64 + 32*r +: 32]);
            end
        if (d[324:320] !== h.distinct)
        begin
            errors++;
            $display("%0t: distinct_entries expected %0d got %0d", $time, h.distinct,
                     d[324:320]);
        end
        if (last !== h.last)
        begin
            errors++;
            $display("%0t: final_item expected %b got %b", $time, h.last, last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_level = 0;
            recording  = 1'b0;
            errors     = 0;
            expected_hits.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                recording = cfg_data;
            if (m_axis_tvalid && m_axis_tready)
                check_hit(m_axis_tdata, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                case (s_axis_tdata[1:0])
                    hctk_pkg::OP_RECORD: if (recording) log_trap(s_axis_tdata);
                    hctk_pkg::OP_READ:   rank_hits(s_axis_tdata[296:290]);
                    hctk_pkg::OP_CLEAR:  fill_level = 0;
                    default:   ;
                endcase
        end
        pending_hits = expected_hits.size();
    end

endmodule

// ----- tb/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // operation, trap_address, trap_reg0..7, read_limit, zero padding
    logic [303:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // hit_address, hit_count, snap_reg0..7, distinct_entries, zero padding
    logic [327:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_data = 1'b0;

    int           errors;
    int           pending_hits;
    int           idle_cycles = 0;
    bit           hold_off = 0;
    logic [31:0]  addr_pool [24];

    hit_counter_table_topk_unit dut (.*);

    hctk_checker checker_i (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Most gaps are nil or short, the odd one is long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // The receiver stalls at random. When asked to hold off it keeps tready low
    // for a long stretch so that the table stalls its input behind a read.
    always
    begin
        @(posedge clk);
        if (hold_off)
        begin
            m_axis_tready <= 1'b0;
            repeat (300) @(posedge clk);
            hold_off = 0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(0, 12)) @(posedge clk);
            if ($urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (pick_gap()) @(posedge clk);
            end
        end
    end

    // The watchdog ends the run when no word moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one word. The valid line is lowered only when a gap is taken, so it
    // never drops and rises within the same time step.
    task automatic send_word(input logic [1:0] op, input logic [31:0] addr,
                             input logic [255:0] regs, input logic [6:0] limit);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, limit, regs, addr, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_random_regs(input logic [1:0] op, input logic [31:0] addr,
                                    input logic [6:0] limit);
        logic [255:0] regs;
        for (int r = 0; r < hctk_pkg::SNAP_REGS; r++)
            regs[32*r +: 32] = $urandom;
        send_word(op, addr, regs, limit);
    endtask

    // Wait for every expected word, then allow the last record to settle
    // before writing the recording switch.
    task automatic set_recording(input logic on);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_hits != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= on;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        int          r;
        logic [6:0]  limit;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                limit = 7'd64;
            else if ($urandom_range(0, 3) == 0)
                limit = 7'($urandom_range(0, 64));
            else
                limit = 7'($urandom_range(0, 18));
            if (r < 66)
                send_random_regs(hctk_pkg::OP_RECORD, addr_pool[$urandom_range(0, 23)],
                                 7'($urandom));
            else if (r < 90)
                send_random_regs(hctk_pkg::OP_READ, $urandom, limit);
            else if (r < 94)
                send_random_regs(hctk_pkg::OP_CLEAR, $urandom, 7'($urandom));
            else
                send_random_regs(hctk_pkg::OP_SPARE, $urandom, 7'($urandom));
        end
    endtask

    initial
    begin
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 24; i++)
            addr_pool[i] = $urandom;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Records are ignored while recording is off after reset,
        // and a read of an empty table returns nothing.
        send_word(hctk_pkg::OP_RECORD, 32'h1234_5678, '1, 7'd0);
        send_word(hctk_pkg::OP_READ, 32'h0, '0, 7'd64);
        set_recording(1'b1);
        send_word(hctk_pkg::OP_RECORD, 32'h0000_0000, '0, 7'd0);
        send_word(hctk_pkg::OP_RECORD, 32'hFFFF_FFFF, '1, 7'h7F);
        send_word(hctk_pkg::OP_RECORD, 32'hFFFF_FFFF, '0, 7'd0);
        send_word(hctk_pkg::OP_READ, 32'h0, '0, 7'd0);
        send_word(hctk_pkg::OP_READ, 32'hFFFF_FFFF, '1, 7'd64);
        send_word(hctk_pkg::OP_SPARE, 32'hFFFF_FFFF, '1, 7'h7F);
        send_word(hctk_pkg::OP_CLEAR, 32'h0, '0, 7'd0);
        send_word(hctk_pkg::OP_READ, 32'h0, '0, 7'd5);
        // Fill the table past its capacity; the last new address is dropped.
        for (int i = 0; i < hctk_pkg::MAX_HITS + 1; i++)
            send_random_regs(hctk_pkg::OP_RECORD, addr_pool[i + 2], 7'd0);
        send_random_regs(hctk_pkg::OP_RECORD, addr_pool[5], 7'd0);
        send_word(hctk_pkg::OP_READ, 32'h0, '0, 7'd64);

        // Long receiver stall while reads keep coming, so the input backs up.
        hold_off = 1;
        for (int i = 0; i < 4; i++)
            send_random_regs(hctk_pkg::OP_READ, $urandom, 7'd16);

        random_phase(130);
        set_recording(1'b0);
        random_phase(60);
        set_recording(1'b1);
        random_phase(150);
        set_recording(1'b0);
        set_recording(1'b1);
        random_phase(120);

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_hits != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/hctk_pkg.sv
sv/hctk_cell.sv
sv/hit_counter_table_topk_unit.sv
tb/hctk_checker.sv
tb/testbench.sv
